// ===== rtl/tkss_pkg.sv =====
// Package for the top-k score selection unit: payload, entry and cell control types.
package tkss_pkg;

  localparam int IdW       = 32;
  localparam int ScoreW    = 32;
  localparam int RankW     = 4;
  localparam int TopCountW = 5;
  localparam int CfgDataW  = 32;

  localparam logic [TopCountW-1:0] TopCountReset = TopCountW'(16);

  typedef struct packed {
    logic [IdW-1:0]           var_id;
    logic signed [ScoreW-1:0] score;
    logic                     last_in;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]           out_var_id;
    logic signed [ScoreW-1:0] out_score;
    logic [RankW-1:0]         rank;
    logic                     last_out;
  } out_item_t;

  typedef struct packed {
    logic                     valid;
    logic [IdW-1:0]           id;
    logic signed [ScoreW-1:0] score;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== rtl/tkss_cell.sv =====
// One cell of the sorted insertion chain: holds one entry and trades it with its neighbors.
module tkss_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  tkss_pkg::cell_ctrl_t ctrl_i,
  input  tkss_pkg::entry_t    new_i,
  input  tkss_pkg::entry_t    prev_i,
  input  logic                prev_keep_i,
  input  tkss_pkg::entry_t    next_i,
  output tkss_pkg::entry_t    entry_o,
  output logic                keep_o
);
  import tkss_pkg::*;

  logic                     valid_r;
  logic [IdW-1:0]           id_r;
  logic signed [ScoreW-1:0] score_r;
  entry_t                   load_nxt;
  logic                     load_en;

  // Equal scores stay put, so ties keep arrival order.
  assign keep_o = valid_r && ($signed(score_r) >= $signed(new_i.score));

  always_comb begin
    load_nxt = entry_t'('0);
    load_en  = 1'b0;
    if (ctrl_i.shift) begin
      load_nxt = next_i;
      load_en  = 1'b1;
    end else if (ctrl_i.insert && !keep_o) begin
      load_nxt = prev_keep_i ? new_i : prev_i;
      load_en  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_r <= 1'b0;
    end else if (load_en) begin
      valid_r <= load_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      id_r    <= load_nxt.id;
      score_r <= load_nxt.score;
    end
  end

  assign entry_o = '{valid: valid_r, id: id_r, score: score_r};

endmodule

// ===== rtl/top_k_score_select_unit.sv =====
// Top level of the top-k score selection unit: insertion chain, drain control, register port.
//
//  channel | direction | handshake                      | payload
//  --------+-----------+--------------------------------+-----------------------------
//  in_     | in        | in_valid / in_ready            | var_id, score, last_in
//  out_    | out       | out_valid / out_ready          | out_var_id, out_score, rank,
//          |           |                                | last_out
//  cfg     | in/out    | psel, penable, pwrite, pready  | top_count at byte address 0
//
// Collecting: one item per cycle; every cell compares its score with the new
// one in parallel and the chain opens a slot below all entries of equal or
// higher score. An item that loses to a full chain is dropped.
// After a transfer with last_in set, the chain shifts toward its head once per
// result taken and drains min(n, k, MAX_K) results for a set of n items; an
// out_ready stall holds the drain, and in_ready stays low while draining.
// The output register lets the last
// result wait on out_ready while the next set already streams in.
// Reset (synchronous, rst_n low) empties the chain and sets top_count to 16.
module top_k_score_select_unit #(
  parameter int MAX_K = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  tkss_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output tkss_pkg::out_item_t                  out_data,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [1:0]                           paddr,
  input  logic [tkss_pkg::CfgDataW-1:0]        pwdata,
  output logic [tkss_pkg::CfgDataW-1:0]        prdata,
  output logic                                 pready
);
  import tkss_pkg::*;

  localparam int CW = $clog2(MAX_K + 1);
  localparam int NW = (CW > TopCountW) ? CW : TopCountW;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

  state_t                 state_r;
  logic [TopCountW-1:0]   top_count_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          remain_r;
  logic [RankW-1:0]       rank_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  entry_t                 cell_q   [MAX_K];
  entry_t                 prev_e   [MAX_K];
  entry_t                 next_e   [MAX_K];
  logic                   keep     [MAX_K];
  logic                   prev_keep[MAX_K];
  cell_ctrl_t             ctrl;
  entry_t                 new_e;

  logic                   in_fire;
  logic                   emit;
  logic                   stored;
  logic [CW-1:0]          count_ins;
  logic [NW-1:0]          k_eff;
  logic [NW-1:0]          n_res;

  // Register port: a single register, any address maps to it.
  assign pready = 1'b1;
  assign prdata = CfgDataW'(top_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= TopCountReset;
    end else if (psel && penable && pwrite) begin
      top_count_r <= pwdata[TopCountW-1:0];
    end
  end

  assign in_ready = (state_r == ST_COLLECT);
  assign in_fire  = in_valid && in_ready;
  assign emit     = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);

  assign new_e = '{valid: 1'b1, id: in_data.var_id, score: in_data.score};

  // The item is stored unless every cell holds an entry that beats or ties it.
  assign stored    = !keep[MAX_K-1];
  assign count_ins = (stored && count_r != CW'(MAX_K)) ? count_r + CW'(1) : count_r;

  // Clamp k to the chain length, then report min(entries held, k).
  always_comb begin
    k_eff = NW'(top_count_r);
    if (k_eff > NW'(MAX_K)) begin
      k_eff = NW'(MAX_K);
    end
    n_res = NW'(count_ins);
    if (n_res > k_eff) begin
      n_res = k_eff;
    end
  end

  always_comb begin
    ctrl.insert = in_fire;
    ctrl.shift  = emit;
    // Drop the chain once the last result leaves, or at once when none is due.
    ctrl.clear  = (in_fire && in_data.last_in && n_res == '0) ||
                  (emit && remain_r == CW'(1));
  end

  // Chain wiring: the head sees an upper neighbor that always keeps, so a new
  // top score lands there; the tail shifts in an empty entry.
  for (genvar i = 0; i < MAX_K; i++) begin : g_chain
    if (i == 0) begin : g_head
      assign prev_e[i]    = entry_t'('0);
      assign prev_keep[i] = 1'b1;
    end else begin : g_body
      assign prev_e[i]    = cell_q[i-1];
      assign prev_keep[i] = keep[i-1];
    end
    if (i == MAX_K - 1) begin : g_tail
      assign next_e[i] = entry_t'('0);
    end else begin : g_inner
      assign next_e[i] = cell_q[i+1];
    end

    tkss_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (ctrl),
      .new_i      (new_e),
      .prev_i     (prev_e[i]),
      .prev_keep_i(prev_keep[i]),
      .next_i     (next_e[i]),
      .entry_o    (cell_q[i]),
      .keep_o     (keep[i])
    );
  end

  // Sequencer: hold the set count, advance the drain, load and release the
  // output register with the head cell, its position and the end-of-run marker.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      count_r     <= '0;
      remain_r    <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r           <= 1'b1;
        out_data_r.out_var_id <= cell_q[0].id;
        out_data_r.out_score  <= cell_q[0].score;
        out_data_r.rank       <= rank_r;
        out_data_r.last_out   <= (remain_r == CW'(1));
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_COLLECT: begin
          if (in_fire) begin
            if (in_data.last_in) begin
              count_r <= '0;
              rank_r  <= '0;
              if (n_res != '0) begin
                remain_r <= CW'(n_res);
                state_r  <= ST_DRAIN;
              end
            end else begin
              count_r <= count_ins;
            end
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            remain_r <= remain_r - CW'(1);
            rank_r   <= rank_r + RankW'(1);
            if (remain_r == CW'(1)) begin
              state_r <= ST_COLLECT;
            end
          end
        end
        default: begin
          state_r <= ST_COLLECT;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
